// ===== sv/ssdw_pkg.sv =====
`default_nettype none

package ssdw_pkg;

    // Configuration register indexes
    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_DOT_EN     = 1'b1;

    localparam int ACK_TIMEOUT_DEFAULT = 200;

    localparam logic [2:0] BRIGHTNESS_RESET = 3'd2;
    localparam logic       DOT_EN_RESET     = 1'b1;

    // Display controller command bytes
    localparam logic [7:0] CMD_MODE_FIXED = 8'h44;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY    = 8'h88;
    localparam logic [7:0] SEG_POINT      = 8'h80;

    // Frame elements, numbered 1..NUM_ELEMS
    localparam logic [3:0] NUM_ELEMS      = 4'd10;
    localparam logic [3:0] ELEM_MODE      = 4'd2;
    localparam logic [3:0] ELEM_ADDR      = 4'd5;
    localparam logic [3:0] ELEM_SEGS      = 4'd6;
    localparam logic [2:0] LAST_BIT       = 3'd7;

    // Sub-steps of a byte element
    localparam logic [3:0] BSUB_CLK_LOW   = 4'd0;
    localparam logic [3:0] BSUB_DATA      = 4'd1;
    localparam logic [3:0] BSUB_CLK_HIGH  = 4'd2;
    localparam logic [3:0] BSUB_ACK_CLKLO = 4'd3;
    localparam logic [3:0] BSUB_ACK_DIO   = 4'd4;
    localparam logic [3:0] BSUB_ACK_CLKHI = 4'd5;
    localparam logic [3:0] BSUB_RELEASE   = 4'd6;
    localparam logic [3:0] BSUB_POLL      = 4'd7;
    localparam logic [3:0] BSUB_REDRIVE   = 4'd8;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_BYTE,
        KIND_STOP
    } kind_t;

    typedef struct packed {
        logic       request;
        logic [1:0] position;
        logic [3:0] digit;
        logic       blank;
        logic       dio_in;
    } item_t;

    typedef struct packed {
        logic clk_out;
        logic dio_out;
        logic dio_drive;
        logic busy_res;
        logic done_res;
    } result_t;

    function automatic kind_t elem_kind(input logic [3:0] elem);
        kind_t k;
        case (elem)
            4'd1, 4'd4, 4'd8:        k = KIND_START;
            4'd2, 4'd5, 4'd6, 4'd9:  k = KIND_BYTE;
            default:                 k = KIND_STOP;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] seg_encode(input logic [3:0] digit);
        logic [7:0] s;
        case (digit)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Byte sent by a byte element (1-based element number)
    function automatic logic [7:0] load_byte(input logic [3:0] elem,
                                             input logic [1:0] pos,
                                             input logic [7:0] segs,
                                             input logic [2:0] bright);
        logic [7:0] b;
        case (elem)
            ELEM_MODE: b = CMD_MODE_FIXED;
            ELEM_ADDR: b = CMD_ADDRESS | {6'd0, pos};
            ELEM_SEGS: b = segs;
            default:   b = CMD_DISPLAY + {5'd0, bright};
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssdw_sequencer.sv =====
`default_nettype none

module ssdw_sequencer #(
    parameter int ACK_TIMEOUT = ssdw_pkg::ACK_TIMEOUT_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire ssdw_pkg::item_t   item,
    input  wire logic [2:0]        brightness,
    input  wire logic              dot_en,
    output ssdw_pkg::result_t      result
);

    localparam logic [7:0] ACK_LIMIT = 8'(ACK_TIMEOUT);

    logic [7:0] step_reg, step_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] ack_cnt_reg, ack_cnt_next;
    logic [1:0] pos_reg, pos_next;
    logic [7:0] segs_reg, segs_next;
    logic       clk_reg, clk_next;
    logic       dio_reg, dio_next;
    logic       drv_reg, drv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            shift_reg   <= '0;
            bit_cnt_reg <= '0;
            ack_cnt_reg <= '0;
            pos_reg     <= '0;
            segs_reg    <= '0;
            clk_reg     <= 1'b1;
            dio_reg     <= 1'b1;
            drv_reg     <= 1'b1;
        end else if (step_en) begin
            step_reg    <= step_next;
            shift_reg   <= shift_next;
            bit_cnt_reg <= bit_cnt_next;
            ack_cnt_reg <= ack_cnt_next;
            pos_reg     <= pos_next;
            segs_reg    <= segs_next;
            clk_reg     <= clk_next;
            dio_reg     <= dio_next;
            drv_reg     <= drv_next;
        end
    end

    always_comb begin
        logic [3:0] elem;
        logic [3:0] sub;
        logic [3:0] nsub;
        logic [3:0] elem_nxt;
        logic [7:0] seg;
        logic [7:0] ack_inc;
        logic       adv;
        logic       busy;
        logic       done;

        step_next    = step_reg;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        ack_cnt_next = ack_cnt_reg;
        pos_next     = pos_reg;
        segs_next    = segs_reg;
        clk_next     = clk_reg;
        dio_next     = dio_reg;
        drv_next     = drv_reg;

        elem     = step_reg[7:4];
        sub      = step_reg[3:0];
        nsub     = sub + 4'd1;
        elem_nxt = elem + 4'd1;
        seg      = '0;
        ack_inc  = ack_cnt_reg + 8'd1;
        adv      = 1'b0;
        busy     = 1'b0;
        done     = 1'b0;

        if (step_reg == 8'd0) begin
            if (item.request) begin
                if (!item.blank) seg = ssdw_pkg::seg_encode(item.digit);
                if (dot_en) seg = seg | ssdw_pkg::SEG_POINT;
                pos_next  = item.position;
                segs_next = seg;
                step_next = 8'h10;
                busy      = 1'b1;
            end
        end else begin
            busy = 1'b1;
            if (!(elem inside {[4'd1:ssdw_pkg::NUM_ELEMS]})) begin
                step_next = '0;
            end else begin
                case (ssdw_pkg::elem_kind(elem))
                    ssdw_pkg::KIND_START: begin
                        case (sub)
                            4'd0:    clk_next = 1'b1;
                            4'd1:    dio_next = 1'b1;
                            4'd2:    dio_next = 1'b0;
                            default: clk_next = 1'b0;
                        endcase
                        if (sub >= 4'd3) adv = 1'b1;
                        else step_next = step_reg + 8'd1;
                    end
                    ssdw_pkg::KIND_STOP: begin
                        case (sub)
                            4'd0:    clk_next = 1'b0;
                            4'd1:    dio_next = 1'b0;
                            4'd2:    clk_next = 1'b1;
                            default: dio_next = 1'b1;
                        endcase
                        if (sub >= 4'd3) adv = 1'b1;
                        else step_next = step_reg + 8'd1;
                    end
                    default: begin
                        case (sub)
                            ssdw_pkg::BSUB_CLK_LOW: clk_next = 1'b0;
                            ssdw_pkg::BSUB_DATA: begin
                                dio_next   = shift_reg[0];
                                shift_next = {1'b0, shift_reg[7:1]};
                            end
                            ssdw_pkg::BSUB_CLK_HIGH: begin
                                clk_next = 1'b1;
                                if (bit_cnt_reg == ssdw_pkg::LAST_BIT) begin
                                    bit_cnt_next = '0;
                                    nsub         = ssdw_pkg::BSUB_ACK_CLKLO;
                                end else begin
                                    bit_cnt_next = bit_cnt_reg + 3'd1;
                                    nsub         = ssdw_pkg::BSUB_CLK_LOW;
                                end
                            end
                            ssdw_pkg::BSUB_ACK_CLKLO: clk_next = 1'b0;
                            ssdw_pkg::BSUB_ACK_DIO:   dio_next = 1'b1;
                            ssdw_pkg::BSUB_ACK_CLKHI: clk_next = 1'b1;
                            ssdw_pkg::BSUB_RELEASE: begin
                                drv_next     = 1'b0;
                                ack_cnt_next = '0;
                            end
                            ssdw_pkg::BSUB_POLL: begin
                                // high line: no ack yet; give up after ACK_TIMEOUT polls
                                if (item.dio_in) begin
                                    if (ack_inc >= ACK_LIMIT) begin
                                        drv_next     = 1'b1;
                                        dio_next     = 1'b0;
                                        ack_cnt_next = '0;
                                    end else begin
                                        ack_cnt_next = ack_inc;
                                        nsub         = ssdw_pkg::BSUB_POLL;
                                    end
                                end
                            end
                            default: begin
                                drv_next = 1'b1;
                                adv      = 1'b1;
                            end
                        endcase
                        if (!adv) step_next = {elem, nsub};
                    end
                endcase

                if (adv) begin
                    if (elem >= ssdw_pkg::NUM_ELEMS) begin
                        step_next = '0;
                        done      = 1'b1;
                    end else begin
                        step_next = {elem_nxt, 4'd0};
                        if (ssdw_pkg::elem_kind(elem_nxt) == ssdw_pkg::KIND_BYTE) begin
                            shift_next   = ssdw_pkg::load_byte(elem_nxt, pos_reg,
                                                               segs_reg, brightness);
                            bit_cnt_next = '0;
                        end
                    end
                end
            end
        end

        result.clk_out   = clk_next;
        result.dio_out   = dio_next;
        result.dio_drive = drv_next;
        result.busy_res  = busy;
        result.done_res  = done;
    end

endmodule

`default_nettype wire

// ===== sv/seven_segment_serial_digit_writer.sv =====
`default_nettype none

// Two-wire seven-segment display writer. Every input beat is one pin-timing
// tick and yields exactly one output beat with the clock/data line levels
// after that tick. While idle, a beat with request=1 latches position and
// digit (blank, or a digit above nine, gives no segments; dot_en adds the
// point bit) and starts three frames: mode 0x44, address 0xC0|position plus
// the segment byte, and display control 0x88+brightness. Bytes go out LSB
// first, three ticks per bit, then an acknowledge wait that polls dio_in
// (low = ack) and forces the line low after ACK_TIMEOUT high polls.
// Requests while busy are ignored. busy_res is high from the request tick
// through the final tick; done_res (m_tlast) marks the final tick.
// Rate: one beat per clock unless m_tready stalls; the sequencer's
// next-state logic sits between the input port and the output register,
// which also lets a new beat in while the previous result is still being
// taken. brightness is sampled when the display control byte is loaded;
// dot_en when a request is latched. Write configuration only while idle.
module seven_segment_serial_digit_writer #(
    parameter int ACK_TIMEOUT = ssdw_pkg::ACK_TIMEOUT_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // config write port
    input  wire logic        cfg_wen,
    input  wire logic        cfg_idx,
    input  wire logic [2:0]  cfg_wdata,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] request, [2:1] position, [6:3] digit, [7] blank, [8] dio_in, [15:9] zero
    input  wire logic [15:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] clk_out, [1] dio_out, [2] dio_drive, [3] busy_res, [7:4] zero
    output logic [7:0]       m_tdata,
    output logic             m_tlast     // done_res
);

    logic [2:0]        brightness_reg;
    logic              dot_en_reg;
    logic              m_tvalid_reg;
    ssdw_pkg::result_t result_reg;
    ssdw_pkg::result_t result_next;
    ssdw_pkg::item_t   item;
    logic              accept;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= ssdw_pkg::BRIGHTNESS_RESET;
            dot_en_reg     <= ssdw_pkg::DOT_EN_RESET;
        end else if (cfg_wen) begin
            case (cfg_idx)
                ssdw_pkg::REG_BRIGHTNESS: brightness_reg <= cfg_wdata;
                ssdw_pkg::REG_DOT_EN:     dot_en_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign item.request  = s_tdata[0];
    assign item.position = s_tdata[2:1];
    assign item.digit    = s_tdata[6:3];
    assign item.blank    = s_tdata[7];
    assign item.dio_in   = s_tdata[8];

    // Output register frees up whenever the sink takes its beat
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ssdw_sequencer #(
        .ACK_TIMEOUT (ACK_TIMEOUT)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (accept),
        .item       (item),
        .brightness (brightness_reg),
        .dot_en     (dot_en_reg),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, result_reg.busy_res, result_reg.dio_drive,
                       result_reg.dio_out, result_reg.clk_out};
    assign m_tlast  = result_reg.done_res;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Poll-window cap used by both the block and the predictor.
    localparam int ACK_LIMIT = ssdw_pkg::ACK_TIMEOUT_DEFAULT;

    // Slowest legal run: roughly 1700 beats, each waiting out the longest
    // sender gap and receiver stall, plus one long receiver hold-off and
    // the config writes. The watchdog allows many times that.
    localparam int CYCLE_LIMIT = 200_000;

    // Segment patterns for the decimal digits.
    localparam logic [7:0] SEG_CODE [0:9] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // Frame elements 1..10: mode frame, address+segments frame, control frame.
    localparam ssdw_pkg::kind_t FRAME_KIND [1:10] = '{
        ssdw_pkg::KIND_START, ssdw_pkg::KIND_BYTE, ssdw_pkg::KIND_STOP,
        ssdw_pkg::KIND_START, ssdw_pkg::KIND_BYTE, ssdw_pkg::KIND_BYTE, ssdw_pkg::KIND_STOP,
        ssdw_pkg::KIND_START, ssdw_pkg::KIND_BYTE, ssdw_pkg::KIND_STOP
    };

    // How the simulated display answers during an acknowledge poll.
    typedef enum logic [1:0] {
        ACK_PROMPT,     // low about half of the polls
        ACK_LATE,       // mostly high, low now and then
        ACK_NEVER       // never answers: poll window runs out
    } ack_style_t;

    // Beats right after reset whose results are obvious by inspection.
    typedef struct packed {
        ssdw_pkg::item_t   beat;
        ssdw_pkg::result_t want;
    } typed_beat_t;

    // One directed digit write: register setting plus the request.
    typedef struct packed {
        logic [2:0] bright;
        logic       point;
        logic [1:0] pos;
        logic [3:0] digit;
        logic       blank;
        ack_style_t style;
    } write_case_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wen;
    logic        cfg_idx;
    logic [2:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    seven_segment_serial_digit_writer #(
        .ACK_TIMEOUT(ACK_LIMIT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer, at reset values.
    // ------------------------------------------------------------------
    logic [7:0] wr_step  = 8'h00;   // [7:4] frame element, [3:0] sub-step
    logic [7:0] wr_shift = 8'h00;
    logic [2:0] wr_bits  = 3'd0;
    logic [7:0] wr_polls = 8'h00;
    logic [1:0] wr_pos   = 2'd0;
    logic [7:0] wr_segs  = 8'h00;
    logic       ln_clk   = 1'b1;
    logic       ln_dio   = 1'b1;
    logic       ln_drv   = 1'b1;
    logic [2:0] cfg_bright = ssdw_pkg::BRIGHTNESS_RESET;
    logic       cfg_point  = ssdw_pkg::DOT_EN_RESET;

    // Results still owed by the block, oldest first.
    ssdw_pkg::result_t pending_levels [$];

    int  fail_count  = 0;
    int  shown_fails = 0;
    int  sent_beats  = 0;       // every input beat taken by the block
    int  sender_gap  = 0;       // idle cycles before the next input beat
    int  hold_ticks  = 0;       // long receiver hold-off, taken once
    bit  no_idle     = 1'b0;    // both sides back to back
    int  cycle_count = 0;

    // Moves past frame element elem; returns 1 when the write is complete.
    function automatic bit next_element(input logic [3:0] elem);
        logic [3:0] nxt;
        if (elem >= ssdw_pkg::NUM_ELEMS) begin
            wr_step = 8'h00;
            return 1'b1;
        end
        nxt = elem + 4'd1;
        wr_step = {nxt, 4'd0};
        if (FRAME_KIND[nxt] == ssdw_pkg::KIND_BYTE) begin
            wr_bits = 3'd0;
            case (nxt)
                ssdw_pkg::ELEM_MODE: wr_shift = ssdw_pkg::CMD_MODE_FIXED;
                ssdw_pkg::ELEM_ADDR: wr_shift = ssdw_pkg::CMD_ADDRESS | {6'd0, wr_pos};
                ssdw_pkg::ELEM_SEGS: wr_shift = wr_segs;
                // brightness read here
                default: wr_shift = ssdw_pkg::CMD_DISPLAY + {5'd0, cfg_bright};
            endcase
        end
        return 1'b0;
    endfunction

    // One sequencer tick: advances the private state, returns the line levels.
    function automatic ssdw_pkg::result_t tick_lines(input ssdw_pkg::item_t it);
        ssdw_pkg::result_t r;
        logic [3:0] elem;
        logic [3:0] sub;
        logic [7:0] seg;
        int         nsub;
        bit         busy;
        bit         done;
        busy = 1'b0;
        done = 1'b0;
        elem = wr_step[7:4];
        sub  = wr_step[3:0];
        if (wr_step == 8'h00) begin
            if (it.request) begin
                // blank or a digit above nine lights nothing; point still applies
                seg = 8'h00;
                if (!it.blank && it.digit < 4'd10) seg = SEG_CODE[it.digit];
                if (cfg_point) seg = seg | ssdw_pkg::SEG_POINT;
                wr_pos  = it.position;
                wr_segs = seg;
                wr_step = 8'h10;
                busy = 1'b1;
            end
        end else begin
            busy = 1'b1;
            if (elem == 4'd0 || elem > ssdw_pkg::NUM_ELEMS) begin
                wr_step = 8'h00;
            end else if (FRAME_KIND[elem] == ssdw_pkg::KIND_START) begin
                // clk high, dio high, dio low, clk low
                case (sub)
                    4'd0:    ln_clk = 1'b1;
                    4'd1:    ln_dio = 1'b1;
                    4'd2:    ln_dio = 1'b0;
                    default: ln_clk = 1'b0;
                endcase
                if (sub >= 4'd3) done = next_element(elem);
                else wr_step = wr_step + 8'd1;
            end else if (FRAME_KIND[elem] == ssdw_pkg::KIND_STOP) begin
                // clk low, dio low, clk high, dio high
                case (sub)
                    4'd0:    ln_clk = 1'b0;
                    4'd1:    ln_dio = 1'b0;
                    4'd2:    ln_clk = 1'b1;
                    default: ln_dio = 1'b1;
                endcase
                if (sub >= 4'd3) done = next_element(elem);
                else wr_step = wr_step + 8'd1;
            end else begin
                nsub = int'(sub) + 1;
                case (sub)
                    ssdw_pkg::BSUB_CLK_LOW: ln_clk = 1'b0;
                    ssdw_pkg::BSUB_DATA: begin
                        ln_dio   = wr_shift[0];
                        wr_shift = wr_shift >> 1;
                    end
                    ssdw_pkg::BSUB_CLK_HIGH: begin
                        ln_clk = 1'b1;
                        if (wr_bits >= ssdw_pkg::LAST_BIT) begin
                            wr_bits = 3'd0;
                            nsub = int'(ssdw_pkg::BSUB_ACK_CLKLO);
                        end else begin
                            wr_bits = wr_bits + 3'd1;
                            nsub = int'(ssdw_pkg::BSUB_CLK_LOW);
                        end
                    end
                    ssdw_pkg::BSUB_ACK_CLKLO: ln_clk = 1'b0;
                    ssdw_pkg::BSUB_ACK_DIO:   ln_dio = 1'b1;
                    ssdw_pkg::BSUB_ACK_CLKHI: ln_clk = 1'b1;
                    ssdw_pkg::BSUB_RELEASE: begin
                        ln_drv   = 1'b0;
                        wr_polls = 8'h00;
                    end
                    ssdw_pkg::BSUB_POLL: begin
                        if (it.dio_in) begin
                            wr_polls = wr_polls + 8'd1;
                            if (wr_polls >= ACK_LIMIT) begin
                                // poll window exhausted: pull the line low, move on
                                ln_drv   = 1'b1;
                                ln_dio   = 1'b0;
                                wr_polls = 8'h00;
                            end else begin
                                nsub = int'(ssdw_pkg::BSUB_POLL);
                            end
                        end
                    end
                    default: begin
                        ln_drv = 1'b1;
                        nsub = 16;
                    end
                endcase
                if (nsub >= 16) done = next_element(elem);
                else wr_step = {elem, nsub[3:0]};
            end
        end
        r.clk_out   = ln_clk;
        r.dio_out   = ln_dio;
        r.dio_drive = ln_drv;
        r.busy_res  = busy;
        r.done_res  = done;
        return r;
    endfunction

    // True while the sequencer sits in an acknowledge poll.
    function automatic bit in_poll();
        return wr_step != 8'h00 && wr_step[7:4] <= ssdw_pkg::NUM_ELEMS
            && FRAME_KIND[wr_step[7:4]] == ssdw_pkg::KIND_BYTE
            && wr_step[3:0] == ssdw_pkg::BSUB_POLL;
    endfunction

    function automatic logic ack_level(input ack_style_t style);
        logic lvl;
        case (style)
            ACK_PROMPT: lvl = logic'($urandom_range(0, 1));
            ACK_LATE:   lvl = ($urandom_range(0, 29) == 0) ? 1'b0 : 1'b1;
            default:    lvl = 1'b1;
        endcase
        return lvl;
    endfunction

    function automatic ssdw_pkg::item_t random_beat();
        ssdw_pkg::item_t it;
        it.request  = logic'($urandom_range(0, 1));
        it.position = 2'($urandom_range(0, 3));
        it.digit    = 4'($urandom_range(0, 15));
        it.blank    = logic'($urandom_range(0, 1));
        it.dio_in   = logic'($urandom_range(0, 1));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a run that hangs ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one beat, waits for the handshake, books the expected levels.
    // Valid is only dropped when the next beat is not back to back.
    task automatic send_tick(input ssdw_pkg::item_t it, input bit typed,
                             input ssdw_pkg::result_t want);
        ssdw_pkg::result_t pred;
        if (sender_gap != 0) repeat (sender_gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.dio_in, it.blank, it.digit, it.position, it.request};
        do @(posedge aclk); while (!s_tready);
        sent_beats++;
        pred = tick_lines(it);
        pending_levels.push_back(typed ? want : pred);
        sender_gap = no_idle ? 0 : $urandom_range(0, 6);
        if (sender_gap != 0) s_tvalid <= 1'b0;
    endtask

    // Stops offering and waits until every owed result has come back.
    // Every beat yields a result, so an empty queue means the block is idle.
    task automatic drain_block();
        if (sender_gap == 0) s_tvalid <= 1'b0;
        sender_gap = 0;
        do @(posedge aclk); while (pending_levels.size() != 0);
    endtask

    // Both registers, written back to back while the block is idle.
    task automatic set_display(input logic [2:0] bright, input logic point);
        drain_block();
        cfg_wen   <= 1'b1;
        cfg_idx   <= ssdw_pkg::REG_BRIGHTNESS;
        cfg_wdata <= bright;
        @(posedge aclk);
        cfg_bright = bright;
        cfg_idx   <= ssdw_pkg::REG_DOT_EN;
        cfg_wdata <= {2'b00, point};
        @(posedge aclk);
        cfg_point = point;
        cfg_wen   <= 1'b0;
    endtask

    // Request beat, then random beats until the predictor goes idle again.
    // Requests in the middle are random and must be ignored. A slow or
    // missing answer hits only the mode byte's window, the rest ack quickly.
    task automatic run_digit(input logic [1:0] pos, input logic [3:0] digit,
                             input logic blank, input ack_style_t style);
        ssdw_pkg::item_t it;
        it = random_beat();
        it.request  = 1'b1;
        it.position = pos;
        it.digit    = digit;
        it.blank    = blank;
        send_tick(it, 1'b0, '0);
        while (wr_step != 8'h00) begin
            it = random_beat();
            if (in_poll())
                it.dio_in = (wr_step[7:4] == ssdw_pkg::ELEM_MODE) ? ack_level(style)
                                                                  : ack_level(ACK_PROMPT);
            send_tick(it, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    task automatic check_levels(input logic [7:0] data, input logic last);
        ssdw_pkg::result_t want;
        if (pending_levels.size() == 0) begin
            fail_count++;
            if (shown_fails < 10) begin
                shown_fails++;
                $display("result beat with nothing owed: %0b%0b%0b%0b%0b",
                         data[0], data[1], data[2], data[3], last);
            end
        end else begin
            want = pending_levels.pop_front();
            if (data[0] !== want.clk_out || data[1] !== want.dio_out
                    || data[2] !== want.dio_drive || data[3] !== want.busy_res
                    || last !== want.done_res) begin
                fail_count++;
                if (shown_fails < 10) begin
                    shown_fails++;
                    // clk dio drv busy done
                    $display("level mismatch: want %0b%0b%0b%0b%0b got %0b%0b%0b%0b%0b",
                             want.clk_out, want.dio_out, want.dio_drive, want.busy_res,
                             want.done_res, data[0], data[1], data[2], data[3], last);
                end
            end
        end
    endtask

    initial begin
        int gap;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_ticks != 0) begin
                // long hold-off: the block fills up and backs up its input
                gap = hold_ticks;
                hold_ticks = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_levels(m_tdata, m_tlast);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Right after reset (brightness 2, point on): idle beats, a request,
    // the start condition and the first bit of the mode byte.
    typed_beat_t typed_beats [10] = '{
        // idle, all fields high where allowed: nothing moves
        '{'{1'b0, 2'd3, 4'd15, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        // idle, all zero
        '{'{1'b0, 2'd0, 4'd0,  1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        // request: latches, lines unchanged, busy
        '{'{1'b1, 2'd0, 4'd0,  1'b0, 1'b0}, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
        // request while busy is ignored; start: clk high
        '{'{1'b1, 2'd3, 4'd15, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
        // start: dio high
        '{'{1'b0, 2'd2, 4'd9,  1'b0, 1'b1}, '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0}},
        // start: dio low
        '{'{1'b1, 2'd1, 4'd5,  1'b1, 1'b0}, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0}},
        // start: clk low
        '{'{1'b0, 2'd0, 4'd10, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        // mode byte bit 0: clk low
        '{'{1'b1, 2'd3, 4'd0,  1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        // data = bit 0 of 0x44
        '{'{1'b0, 2'd1, 4'd15, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        // clk high
        '{'{1'b1, 2'd2, 4'd3,  1'b1, 1'b1}, '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0}}
    };

    // Full digit writes, checked against the predictor.
    write_case_t write_cases [6] = '{
        '{3'd0, 1'b0, 2'd0, 4'd0,  1'b0, ACK_PROMPT},   // lowest everything
        '{3'd7, 1'b1, 2'd3, 4'd9,  1'b0, ACK_PROMPT},   // highest everything
        '{3'd7, 1'b0, 2'd1, 4'd15, 1'b0, ACK_LATE},     // digit above nine
        '{3'd3, 1'b1, 2'd2, 4'd10, 1'b0, ACK_PROMPT},   // first digit above nine
        '{3'd5, 1'b0, 2'd2, 4'd8,  1'b1, ACK_PROMPT},   // blank
        '{3'd2, 1'b1, 2'd1, 4'd7,  1'b1, ACK_NEVER}     // acknowledge timeout
    };

    initial begin
        ssdw_pkg::item_t it;
        int    pick;
        bit    first_pass;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_idx   = ssdw_pkg::REG_BRIGHTNESS;
        cfg_wdata = 3'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 16'h0000;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: typed beats, then finish that write with quick acks
        foreach (typed_beats[i])
            send_tick(typed_beats[i].beat, 1'b1, typed_beats[i].want);
        while (wr_step != 8'h00) begin
            it = random_beat();
            if (in_poll()) it.dio_in = ack_level(ACK_PROMPT);
            send_tick(it, 1'b0, '0);
        end

        foreach (write_cases[i]) begin
            set_display(write_cases[i].bright, write_cases[i].point);
            run_digit(write_cases[i].pos, write_cases[i].digit,
                      write_cases[i].blank, write_cases[i].style);
        end

        // random: digit writes with random content, idle noise in between,
        // register changes between writes; the first pass runs back to back
        // under a long receiver hold-off
        first_pass = 1'b1;
        do begin
            if ($urandom_range(0, 4) == 0) begin
                pick = $urandom_range(0, 2);
                set_display(pick == 0 ? 3'd0 : pick == 1 ? 3'd7 : 3'($urandom_range(0, 7)),
                            logic'($urandom_range(0, 1)));
            end
            no_idle = first_pass || ($urandom_range(0, 3) == 0);
            if (first_pass || $urandom_range(0, 5) == 0)
                hold_ticks = $urandom_range(60, 100);
            first_pass = 1'b0;
            repeat ($urandom_range(0, 2)) begin
                it = random_beat();
                it.request = 1'b0;
                send_tick(it, 1'b0, '0);
            end
            pick = $urandom_range(0, 7);
            run_digit(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      logic'($urandom_range(0, 4) == 0),
                      pick == 0 ? ACK_NEVER : pick == 1 ? ACK_LATE : ACK_PROMPT);
        end while (sent_beats < 750);
        no_idle = 1'b0;

        // let the last results come back, then a few more cycles for strays
        drain_block();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending_levels.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ssdw_pkg.sv
sv/ssdw_sequencer.sv
sv/seven_segment_serial_digit_writer.sv
tb/tb.sv
